// File: src/fcms_pkg.sv
// Shared types and constants for the four-channel median sampler.
package fcms_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int RAW_WIDTH    = 24;
   localparam int BYTE_WIDTH   = 8;
   localparam int PERIOD_WIDTH = 16;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd40;

   // register word index, taken from paddr[2]
   localparam logic CSR_IDX_SNAPSHOT_PERIOD = 1'b0;

   // snapshots held between front and back
   localparam int QUEUE_DEPTH = 2;

   // queue fill status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // back-end sequencer states
   typedef enum logic {
      BK_IDLE,
      BK_SEND
   } back_state_type;

endpackage

// File: src/fcms_front.sv
// Front end: sample rings, per-channel median, round counter and snapshot push.
module fcms_front #(
   parameter int NUM_CHANNELS = 4,
   parameter int WINDOW       = 5
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [fcms_pkg::RAW_WIDTH-1:0]           req_raw_word,
   input  logic                                     req_queue_room,
   input  logic [fcms_pkg::PERIOD_WIDTH-1:0]        snapshot_period,
   input  fcms_pkg::queue_status_type               q_status,
   output logic                                     push_valid,
   output logic [NUM_CHANNELS*fcms_pkg::SAMPLE_WIDTH-1:0] push_data
);

   localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int POS_W    = $clog2(WINDOW);
   localparam int RANK_W   = $clog2(WINDOW);
   localparam int MED_RANK = WINDOW / 2;
   localparam int SW       = fcms_pkg::SAMPLE_WIDTH;

   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [POS_W-1:0]  pos_ff [NUM_CHANNELS];
   logic [POS_W-1:0]  pos_cur, pos_next;
   logic [SW-1:0]     ring_ff [NUM_CHANNELS][WINDOW];
   logic [SW-1:0]     med_ff [NUM_CHANNELS];
   logic [fcms_pkg::PERIOD_WIDTH-1:0] rc_ff, rc_in, rc_inc;

   logic              accept;
   logic [SW-1:0]     sample;
   logic [SW-1:0]     row [WINDOW];
   logic [RANK_W-1:0] rank [WINDOW];
   logic [SW-1:0]     new_med;
   logic              last_ch;
   logic              snap_due;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign sample    = req_raw_word[SW:1];
   assign pos_cur   = pos_ff[ch_ff];
   assign pos_next  = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + 1'b1;
   assign last_ch   = (ch_ff == CH_W'(NUM_CHANNELS - 1));
   assign ch_in     = last_ch ? '0 : ch_ff + 1'b1;

   // ring row of the current channel with the new sample in place
   always_comb begin
      for (int w = 0; w < WINDOW; w++) begin
         row[w] = (pos_cur == POS_W'(w)) ? sample : ring_ff[ch_ff][w];
      end
   end

   // descending rank of each entry, ties broken by position
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW; j++) begin
            if (j != i) begin
               if ((row[j] > row[i]) || ((row[j] == row[i]) && (j < i))) begin
                  rank[i] = rank[i] + 1'b1;
               end
            end
         end
      end
   end

   // the entry of middle rank is the median
   always_comb begin
      new_med = '0;
      for (int i = 0; i < WINDOW; i++) begin
         if (rank[i] == RANK_W'(MED_RANK)) begin
            new_med = new_med | row[i];
         end
      end
   end

   // round counter, counted once per round and reduced by the period when it reaches it
   always_comb begin
      rc_inc   = rc_ff + 1'b1;
      rc_in    = rc_ff;
      snap_due = 1'b0;
      if (last_ch) begin
         rc_in = rc_inc;
         if (rc_inc >= snapshot_period) begin
            rc_in    = rc_inc - snapshot_period;
            snap_due = 1'b1;
         end
      end
   end

   // snapshot: stored medians, last channel taken fresh
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         push_data[c*SW +: SW] = (c == NUM_CHANNELS - 1) ? new_med : med_ff[c];
      end
   end

   assign push_valid = accept && snap_due && req_queue_room;

   // control state and sample rings
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= '0;
         rc_ff <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            pos_ff[c] <= '0;
            for (int w = 0; w < WINDOW; w++) begin
               ring_ff[c][w] <= '0;
            end
         end
      end else if (accept) begin
         ch_ff         <= ch_in;
         rc_ff         <= rc_in;
         pos_ff[ch_ff] <= pos_next;
         ring_ff[ch_ff][pos_cur] <= sample;
      end
   end

   // medians, undefined until first written
   always_ff @(posedge clock) begin
      if (accept) begin
         med_ff[ch_ff] <= new_med;
      end
   end

endmodule

// File: src/fcms_queue.sv
// Small snapshot queue between front and back.
module fcms_queue #(
   parameter int DATA_W = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [DATA_W-1:0]           push_data,
   input  logic                        pop,
   output logic [DATA_W-1:0]           pop_data,
   output fcms_pkg::queue_status_type  status
);

   localparam int DEPTH = fcms_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   // pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/fcms_back.sv
// Back end: serializes one snapshot into bytes behind an output register.
module fcms_back #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  fcms_pkg::queue_status_type                     q_status,
   input  logic [NUM_CHANNELS*fcms_pkg::SAMPLE_WIDTH-1:0] q_data,
   output logic                                           q_pop,
   output logic                                           rsp_valid,
   input  logic                                           rsp_stall,
   output logic [fcms_pkg::BYTE_WIDTH-1:0]                rsp_out_byte,
   output logic                                           rsp_last_byte
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SW   = fcms_pkg::SAMPLE_WIDTH;
   localparam int BW   = fcms_pkg::BYTE_WIDTH;

   fcms_pkg::back_state_type state_ff, state_in;

   logic [NUM_CHANNELS*SW-1:0] snap_ff;
   logic [CH_W-1:0]            chan_ff, chan_in;
   logic [1:0]                 sub_ff, sub_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]              rsp_byte_ff, rsp_byte_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       adv;
   logic                       load;
   logic                       final_byte;
   logic [SW-1:0]              cur_med;

   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign cur_med    = snap_ff[chan_ff*SW +: SW];
   assign final_byte = (chan_ff == CH_W'(NUM_CHANNELS - 1)) && (sub_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcms_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = fcms_pkg::BK_SEND;
            end
         end
         fcms_pkg::BK_SEND: begin
            if (adv && final_byte) begin
               state_in = fcms_pkg::BK_IDLE;
            end
         end
         default: state_in = fcms_pkg::BK_IDLE;
      endcase
   end

   // outputs: queue pop, byte counters, output register
   always_comb begin
      load         = 1'b0;
      chan_in      = chan_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         fcms_pkg::BK_IDLE: begin
            load = !q_status.empty;
            if (load) begin
               chan_in = '0;
               sub_in  = '0;
            end
            if (adv) begin
               rsp_valid_in = 1'b0;
            end
         end
         fcms_pkg::BK_SEND: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = final_byte;
               case (sub_ff)
                  2'd0:    rsp_byte_in = cur_med[BW-1:0];
                  2'd1:    rsp_byte_in = cur_med[SW-1:BW];
                  default: rsp_byte_in = '0;
               endcase
               if (sub_ff == 2'd2) begin
                  sub_in  = '0;
                  chan_in = chan_ff + 1'b1;
               end else begin
                  sub_in = sub_ff + 1'b1;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   assign q_pop         = load;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcms_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      sub_ff      <= sub_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (load) begin
         snap_ff <= q_data;
      end
   end

endmodule

// File: src/four_channel_median_sampler_top.sv
// Top level of the four-channel median sampler.
//
// Request channel (req_valid / req_stall): one 24-bit converter word per
// transfer plus the downstream room flag. Bits 16..1 are the sample; words
// go round-robin to the channels starting at channel 0. One word can be
// taken every cycle; req_stall rises only while two snapshots wait in the
// queue between the front and the back end.
// Each word updates its channel's five-sample ring and median in the cycle
// it is taken. After the last channel's word a round is counted; when the
// count reaches snapshot_period (APB register 0) and room is flagged, a
// snapshot of all medians is queued.
// Response channel (rsp_valid / rsp_stall): each snapshot leaves as
// 3*NUM_CHANNELS byte transfers, low, middle and zero high byte per channel,
// rsp_last_byte on the final one. A snapshot passes the queue, the back-end
// load and the output register before its first byte, then one byte per
// cycle while not stalled; the back end idles again before the next load.
// A stalled byte holds in the output register; the front keeps accepting
// words until the snapshot queue is full.
// Reset clears rings, ring positions, channel and round counters and sets
// the period to 40.
module four_channel_median_sampler_top #(
   parameter int NUM_CHANNELS = 4,
   parameter int WINDOW       = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fcms_pkg::RAW_WIDTH-1:0]       req_raw_word,
   input  logic                                 req_queue_room,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fcms_pkg::BYTE_WIDTH-1:0]      rsp_out_byte,
   output logic                                 rsp_last_byte,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fcms_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [fcms_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [fcms_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam int SNAP_W = NUM_CHANNELS * fcms_pkg::SAMPLE_WIDTH;

   logic [fcms_pkg::PERIOD_WIDTH-1:0] period_ff;
   logic                              csr_write;
   fcms_pkg::queue_status_type        q_status;
   logic                              push_valid;
   logic [SNAP_W-1:0]                 push_data;
   logic                              q_pop;
   logic [SNAP_W-1:0]                 q_data;

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == fcms_pkg::CSR_IDX_SNAPSHOT_PERIOD);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= fcms_pkg::PERIOD_RESET;
      end else if (csr_write) begin
         period_ff <= pwdata[fcms_pkg::PERIOD_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == fcms_pkg::CSR_IDX_SNAPSHOT_PERIOD) begin
         prdata = {{(fcms_pkg::CSR_DATA_W - fcms_pkg::PERIOD_WIDTH){1'b0}}, period_ff};
      end
   end

   fcms_front #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .WINDOW       (WINDOW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_word    (req_raw_word),
      .req_queue_room  (req_queue_room),
      .snapshot_period (period_ff),
      .q_status        (q_status),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   fcms_queue #(
      .DATA_W (SNAP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   fcms_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// File: src/fcms_checker.sv
// Port-level assertions for the median sampler, bound to the top level.
module fcms_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [fcms_pkg::BYTE_WIDTH-1:0] rsp_out_byte,
   input logic                            rsp_last_byte,
   input logic                            pready
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte)))
      else $error("stalled result changed");

   // the closing byte is a high byte, always zero
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (rsp_out_byte == '0))
      else $error("last byte not zero");

   // a closing byte that is taken is not followed directly by another close
   a_last_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_byte) |=> !(rsp_valid && rsp_last_byte))
      else $error("back-to-back last bytes");

   // the configuration port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind four_channel_median_sampler_top fcms_checker u_fcms_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte),
   .pready        (pready)
);

// File: tb/sv/tb_four_channel_median_sampler_top.sv
// Testbench for the four-channel median sampler: stimulus, filter prediction and byte checks.
`timescale 1ns / 1ps

module tb_four_channel_median_sampler_top;

   localparam int NUM_CH      = 4;
   localparam int WIN         = 5;
   localparam int SNAP_LEN    = 3 * NUM_CH;
   localparam int DRAIN_WAIT  = 20;     // drain time after the last expected byte
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 2000;

   localparam int SW  = fcms_pkg::SAMPLE_WIDTH;
   localparam int RW  = fcms_pkg::RAW_WIDTH;
   localparam int BW  = fcms_pkg::BYTE_WIDTH;
   localparam int PW  = fcms_pkg::PERIOD_WIDTH;
   localparam int DW  = fcms_pkg::CSR_DATA_W;
   localparam int AW  = fcms_pkg::CSR_ADDR_W;

   localparam logic [AW-1:0] PERIOD_ADDR = {fcms_pkg::CSR_IDX_SNAPSHOT_PERIOD, 2'b00};
   localparam logic [PW-1:0] PERIOD_MAX  = 16'hFFFF;
   localparam logic [PW-1:0] PERIOD_MIN  = 16'd1;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_EVERY_THIRD,
      STALL_HEAVY
   } stall_mode_type;

   typedef struct packed {
      logic [RW-1:0] raw;
      logic          room;
   } conv_word_type;

   typedef struct packed {
      logic [BW-1:0] value;
      logic          last;
   } snap_byte_type;

   // DUT ports
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [RW-1:0]    req_raw_word = '0;
   logic             req_queue_room = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [BW-1:0]    rsp_out_byte;
   logic             rsp_last_byte;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [AW-1:0]    paddr = '0;
   logic [DW-1:0]    pwdata = '0;
   logic [DW-1:0]    prdata;
   logic             pready;

   // stimulus and expectations
   conv_word_type pending_words[$];
   snap_byte_type snapshot_bytes[$];
   int         words_queued = 0;
   int         taken = 0;
   int         offered = 0;
   int         errors = 0;
   int         hold_asks = 0;

   // filter state mirrored by the predictor
   logic [1:0]        next_channel;
   logic [WIN*SW-1:0] sample_rings [NUM_CH];
   logic [2:0]        ring_slot [NUM_CH];
   logic [SW-1:0]     channel_medians [NUM_CH];
   logic [PW-1:0]     round_tally;
   logic [PW-1:0]     period_setting = fcms_pkg::PERIOD_RESET;

   four_channel_median_sampler_top #(
      .NUM_CHANNELS(NUM_CH),
      .WINDOW      (WIN)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_raw_word  (req_raw_word),
      .req_queue_room(req_queue_room),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // middle value of the five samples in a ring
   function automatic logic [SW-1:0] median5(input logic [WIN*SW-1:0] ring);
      logic [SW-1:0] v [WIN];
      logic [SW-1:0] t;
      for (int i = 0; i < WIN; i++) v[i] = ring[i*SW +: SW];
      for (int i = 0; i < WIN - 1; i++) begin
         for (int j = i + 1; j < WIN; j++) begin
            if (v[i] > v[j]) begin
               t = v[i];
               v[i] = v[j];
               v[j] = t;
            end
         end
      end
      return v[WIN/2];
   endfunction

   // one converter word through the filter; queues the snapshot bytes it releases
   task automatic advance_filter(input logic [RW-1:0] raw, input logic room);
      logic [1:0]    ch;
      logic [SW-1:0] m;
      snap_byte_type b;
      ch = next_channel;
      sample_rings[ch][ring_slot[ch]*SW +: SW] = raw[16:1];
      ring_slot[ch] = (ring_slot[ch] == WIN - 1) ? 3'd0 : ring_slot[ch] + 3'd1;
      channel_medians[ch] = median5(sample_rings[ch]);
      next_channel = ch + 2'd1;
      if (ch == NUM_CH - 1) begin
         round_tally = round_tally + 16'd1;
         if (round_tally >= period_setting) begin
            round_tally = round_tally - period_setting;
            if (room) begin
               for (int c = 0; c < NUM_CH; c++) begin
                  m = channel_medians[c];
                  b.last = 1'b0;
                  b.value = m[7:0];
                  snapshot_bytes.push_back(b);
                  b.value = m[15:8];
                  snapshot_bytes.push_back(b);
                  b.value = '0;
                  b.last = (c == NUM_CH - 1);
                  snapshot_bytes.push_back(b);
               end
            end
         end
      end
   endtask

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      conv_word_type w;
      if (!reset && !(req_valid && taken != offered)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_raw_word <= w.raw;
            req_queue_room <= w.room;
            req_valid <= 1'b1;
            offered++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern picked anew when its random run ends, plus long holds on request
   stall_mode_type stall_mode = STALL_NONE;
   int          mode_left = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          rsp_cycle = 0;

   always @(negedge clock) begin
      logic nxt;
      if (!reset) begin
         rsp_cycle++;
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:        nxt = 1'b0;
            STALL_LIGHT:       nxt = ($urandom_range(0, 3) == 0);
            STALL_EVERY_THIRD: nxt = (rsp_cycle % 3 == 0);
            default:           nxt = ($urandom_range(0, 9) < 6);
         endcase
         if (hold_left > 0) begin
            nxt = 1'b1;
            hold_left--;
         end
         rsp_stall <= nxt;
      end
   end

   // monitor: predict on accepted words, check accepted bytes, watchdog
   int idle_cycles = 0;

   always @(posedge clock) begin
      bit            moved;
      snap_byte_type want;
      moved = 1'b0;
      if (reset) begin
         next_channel = '0;
         round_tally = '0;
         for (int c = 0; c < NUM_CH; c++) begin
            sample_rings[c] = '0;
            ring_slot[c] = '0;
            channel_medians[c] = '0;
         end
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (snapshot_bytes.size() == 0) begin
               report_mismatch("byte with nothing expected", rsp_out_byte, 0);
            end else begin
               want = snapshot_bytes.pop_front();
               if (rsp_out_byte !== want.value)
                  report_mismatch("out_byte", rsp_out_byte, want.value);
               if (rsp_last_byte !== want.last)
                  report_mismatch("last_byte", rsp_last_byte, want.last);
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            advance_filter(req_raw_word, req_queue_room);
            taken <= taken + 1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // APB setup and access cycles; returns prdata of the access cycle
   task automatic csr_access(input logic wr, input logic [PW-1:0] val,
                             output logic [DW-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= PERIOD_ADDR;
      pwdata <= {{(DW-PW){1'b0}}, val};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_period_readback();
      logic [DW-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== {{(DW-PW){1'b0}}, period_setting})
         report_mismatch("snapshot_period readback", rd, period_setting);
   endtask

   task automatic set_period(input logic [PW-1:0] val);
      logic [DW-1:0] rd;
      csr_access(1'b1, val, rd);
      period_setting = val;
      check_period_readback();
   endtask

   task automatic push_word(input logic [RW-1:0] raw, input logic room);
      conv_word_type w;
      w.raw = raw;
      w.room = room;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // room flag only matters on the channel 3 word, but all four carry it
   task automatic push_round(input logic [RW-1:0] w0, input logic [RW-1:0] w1,
                             input logic [RW-1:0] w2, input logic [RW-1:0] w3,
                             input logic room);
      push_word(w0, room);
      push_word(w1, room);
      push_word(w2, room);
      push_word(w3, room);
   endtask

   // mix of full-range words, extremes and clustered samples so medians tie often
   function automatic logic [RW-1:0] random_word();
      logic [RW-1:0] w;
      w = RW'($urandom);
      case ($urandom_range(0, 5))
         1: w = '0;
         2: w = '1;
         3: w[16:1] = 16'($urandom_range(0, 3));
         4: w[16:1] = 16'hFFFF - 16'($urandom_range(0, 3));
         default: ;
      endcase
      return w;
   endfunction

   task automatic random_rounds(input int n);
      for (int i = 0; i < 4 * n; i++) push_word(random_word(), $urandom_range(0, 9) != 0);
   endtask

   // sender pause: all words taken, all bytes out, then the back end drains
   task automatic settle();
      while (taken != words_queued || snapshot_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      check_period_readback();

      // directed: zeros, max samples, dropped snapshot, ignored bits, bit patterns
      set_period(PERIOD_MIN);
      push_round(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1);
      push_round(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
      push_round(24'h01FFFE, 24'hFFFFFF, 24'h01FFFE, 24'hFFFFFF, 1'b0);
      push_round(24'hFFFFFF, 24'h01FFFE, 24'hFFFFFF, 24'h01FFFE, 1'b1);
      push_round(24'hFE0001, 24'h000001, 24'h800000, 24'h000002, 1'b1);
      push_round(24'hAAAAAA, 24'h555555, 24'h010000, 24'h123456, 1'b1);
      settle();

      // snapshot every round while the receiver holds off: front end must fill and stall
      hold_asks++;
      random_rounds(9);
      settle();

      set_period(16'd3);
      random_rounds(9);
      settle();

      // count climbs under the largest period, then the period drops below it
      set_period(PERIOD_MAX);
      random_rounds(6);
      settle();
      set_period(16'd2);
      random_rounds(9);
      settle();

      set_period(PW'($urandom_range(4, 7)));
      random_rounds(6);
      settle();

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
